@@ hw/rtl/ldh_pkg.sv @@
// Shared types and constants for the link deframer with heartbeat supervision.
// Used by ldh_core, ldh_out_buf and link_deframer_with_heartbeat_unit.
// No dependencies.
`default_nettype none

package ldh_pkg;

    // request command codes
    typedef enum logic [1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_OPEN    = 2'd2,
        CMD_SENT    = 2'd3
    } command_t;

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_BODY_BYTE  = 3'd1,
        EV_DATA_DONE  = 3'd2,
        EV_ACCEPT     = 3'd3,
        EV_HEARTBEAT  = 3'd4,
        EV_ERROR      = 3'd5
    } event_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_HEADER   = 3'd1,
        ERR_UNKNOWN_CODE = 3'd2,
        ERR_TOO_LONG     = 3'd3,
        ERR_BAD_TRAILER  = 3'd4
    } err_t;

    // parser phases: six header bytes, body, two trailer bytes
    typedef enum logic [3:0] {
        PH_HDR0 = 4'd0,
        PH_HDR1 = 4'd1,
        PH_HDR2 = 4'd2,
        PH_HDR3 = 4'd3,
        PH_HDR4 = 4'd4,
        PH_HDR5 = 4'd5,
        PH_BODY = 4'd6,
        PH_TRL0 = 4'd7,
        PH_TRL1 = 4'd8
    } phase_t;

    // kind of frame being parsed
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_ACCEPT    = 2'd1,
        KIND_HEARTBEAT = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] CFG_SEND_IDLE_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_RECEIVE_IDLE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MAX_PACKET         = 2'd2;

    // configuration reset values
    localparam logic [7:0]  SEND_IDLE_LIMIT_RST    = 8'd58;
    localparam logic [7:0]  RECEIVE_IDLE_LIMIT_RST = 8'd30;
    localparam logic [15:0] MAX_PACKET_RST         = 16'd8192;

    // framing marks and ascii digits
    localparam logic [7:0] HDR_MARK    = 8'hFE;
    localparam logic [7:0] TRL_MARK    = 8'hEF;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] COUNT_MAX   = 8'hFF;

    // configuration as seen by the parser
    typedef struct packed {
        logic [7:0]  send_idle_limit;
        logic [7:0]  receive_idle_limit;
        logic [15:0] max_packet;
    } cfg_t;

    // one result item
    typedef struct packed {
        event_t      ev;
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        err_t        error_code;
        logic        send_heartbeat;
        logic        link_closing;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/ldh_core.sv @@
// Frame parser and idle supervision: link state, counters and header store.
// Computes one result per accepted request; depends on ldh_pkg.
`default_nettype none

module ldh_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [1:0]      command,
    input  wire logic [7:0]      rx_byte,
    input  wire ldh_pkg::cfg_t   cfg,
    output ldh_pkg::result_t     result
);

    logic               open_reg, open_next;
    logic [7:0]         send_cnt_reg, send_cnt_next;
    logic [7:0]         rcv_cnt_reg, rcv_cnt_next;
    ldh_pkg::phase_t    phase_reg, phase_next;
    logic [15:0]        body_reg, body_next;
    ldh_pkg::kind_t     kind_reg, kind_next;
    logic [7:0]         hdr_reg [6];
    logic [7:0]         hdr_next [6];

    logic [7:0]         send_inc;
    logic [7:0]         rcv_inc;
    logic [15:0]        hdr_len;
    logic [16:0]        len_plus2;
    logic               do_close;
    ldh_pkg::command_t  cmd;

    assign cmd       = ldh_pkg::command_t'(command);
    assign send_inc  = (send_cnt_reg == ldh_pkg::COUNT_MAX) ? send_cnt_reg : send_cnt_reg + 8'd1;
    assign rcv_inc   = (rcv_cnt_reg == ldh_pkg::COUNT_MAX) ? rcv_cnt_reg : rcv_cnt_reg + 8'd1;
    assign hdr_len   = {hdr_reg[4], rx_byte};
    assign len_plus2 = {1'b0, hdr_len} + 17'd2;

    // next state and result for one request
    always_comb
    begin
        open_next     = open_reg;
        send_cnt_next = send_cnt_reg;
        rcv_cnt_next  = rcv_cnt_reg;
        phase_next    = phase_reg;
        body_next     = body_reg;
        kind_next     = kind_reg;
        hdr_next      = hdr_reg;
        do_close      = 1'b0;

        result.ev             = ldh_pkg::EV_NONE;
        result.data_byte      = 8'd0;
        result.message_length = 16'd0;
        result.error_code     = ldh_pkg::ERR_NONE;
        result.send_heartbeat = 1'b0;
        result.link_closing   = 1'b0;

        unique case (cmd)
            ldh_pkg::CMD_RX_BYTE:
            begin
                if (open_reg)
                begin
                    unique case (phase_reg)
                        ldh_pkg::PH_HDR0:
                        begin
                            hdr_next[0] = rx_byte;
                            phase_next  = ldh_pkg::PH_HDR1;
                        end
                        ldh_pkg::PH_HDR1:
                        begin
                            hdr_next[1] = rx_byte;
                            phase_next  = ldh_pkg::PH_HDR2;
                        end
                        ldh_pkg::PH_HDR2:
                        begin
                            hdr_next[2] = rx_byte;
                            phase_next  = ldh_pkg::PH_HDR3;
                        end
                        ldh_pkg::PH_HDR3:
                        begin
                            hdr_next[3] = rx_byte;
                            phase_next  = ldh_pkg::PH_HDR4;
                        end
                        ldh_pkg::PH_HDR4:
                        begin
                            hdr_next[4] = rx_byte;
                            phase_next  = ldh_pkg::PH_HDR5;
                        end
                        ldh_pkg::PH_HDR5:
                        begin
                            hdr_next[5] = rx_byte;
                            // marks first, then control code
                            if (hdr_reg[0] != ldh_pkg::HDR_MARK ||
                                hdr_reg[1] != ldh_pkg::HDR_MARK)
                            begin
                                do_close          = 1'b1;
                                result.ev         = ldh_pkg::EV_ERROR;
                                result.error_code = ldh_pkg::ERR_BAD_HEADER;
                            end
                            else
                            begin
                                rcv_cnt_next = 8'd0;
                                if (hdr_reg[2] == ldh_pkg::ASCII_ZERO &&
                                    hdr_reg[3] == ldh_pkg::ASCII_ZERO)
                                begin
                                    if (len_plus2 > {1'b0, cfg.max_packet})
                                    begin
                                        do_close          = 1'b1;
                                        result.ev         = ldh_pkg::EV_ERROR;
                                        result.error_code = ldh_pkg::ERR_TOO_LONG;
                                    end
                                    else
                                    begin
                                        kind_next  = ldh_pkg::KIND_DATA;
                                        body_next  = hdr_len;
                                        phase_next = (hdr_len == 16'd0) ? ldh_pkg::PH_TRL0
                                                                        : ldh_pkg::PH_BODY;
                                    end
                                end
                                else if (hdr_reg[2] == ldh_pkg::ASCII_ONE &&
                                         (hdr_reg[3] == ldh_pkg::ASCII_ZERO ||
                                          hdr_reg[3] == ldh_pkg::ASCII_ONE))
                                begin
                                    kind_next  = (hdr_reg[3] == ldh_pkg::ASCII_ZERO)
                                                 ? ldh_pkg::KIND_ACCEPT
                                                 : ldh_pkg::KIND_HEARTBEAT;
                                    phase_next = ldh_pkg::PH_TRL0;
                                end
                                else
                                begin
                                    do_close          = 1'b1;
                                    result.ev         = ldh_pkg::EV_ERROR;
                                    result.error_code = ldh_pkg::ERR_UNKNOWN_CODE;
                                end
                            end
                        end
                        ldh_pkg::PH_BODY:
                        begin
                            result.ev        = ldh_pkg::EV_BODY_BYTE;
                            result.data_byte = rx_byte;
                            body_next        = body_reg - 16'd1;
                            if (body_reg == 16'd1)
                                phase_next = ldh_pkg::PH_TRL0;
                        end
                        ldh_pkg::PH_TRL0:
                        begin
                            // first trailer byte reuses header slot zero
                            hdr_next[0] = rx_byte;
                            phase_next  = ldh_pkg::PH_TRL1;
                        end
                        ldh_pkg::PH_TRL1:
                        begin
                            if (hdr_reg[0] != ldh_pkg::TRL_MARK ||
                                rx_byte != ldh_pkg::TRL_MARK)
                            begin
                                do_close          = 1'b1;
                                result.ev         = ldh_pkg::EV_ERROR;
                                result.error_code = ldh_pkg::ERR_BAD_TRAILER;
                            end
                            else
                            begin
                                phase_next = ldh_pkg::PH_HDR0;
                                unique case (kind_reg)
                                    ldh_pkg::KIND_DATA:
                                    begin
                                        result.ev             = ldh_pkg::EV_DATA_DONE;
                                        result.message_length = {hdr_reg[4], hdr_reg[5]};
                                    end
                                    ldh_pkg::KIND_ACCEPT:
                                        result.ev = ldh_pkg::EV_ACCEPT;
                                    default:
                                        result.ev = ldh_pkg::EV_HEARTBEAT;
                                endcase
                            end
                        end
                        default:
                            phase_next = ldh_pkg::PH_HDR0;
                    endcase
                end
            end
            ldh_pkg::CMD_TICK:
            begin
                if (open_reg)
                begin
                    send_cnt_next = send_inc;
                    rcv_cnt_next  = rcv_inc;
                    if (send_inc >= cfg.send_idle_limit)
                    begin
                        result.send_heartbeat = 1'b1;
                        send_cnt_next         = 8'd0;
                    end
                    if (rcv_inc >= cfg.receive_idle_limit)
                        do_close = 1'b1;
                end
            end
            ldh_pkg::CMD_OPEN:
            begin
                send_cnt_next = 8'd0;
                rcv_cnt_next  = 8'd0;
                phase_next    = ldh_pkg::PH_HDR0;
                body_next     = 16'd0;
                open_next     = 1'b1;
            end
            default:
                send_cnt_next = 8'd0;
        endcase

        // error or receive timeout closes the link
        if (do_close)
        begin
            open_next           = 1'b0;
            send_cnt_next       = 8'd0;
            rcv_cnt_next        = 8'd0;
            phase_next          = ldh_pkg::PH_HDR0;
            body_next           = 16'd0;
            result.link_closing = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            send_cnt_reg <= 8'd0;
            rcv_cnt_reg  <= 8'd0;
            phase_reg    <= ldh_pkg::PH_HDR0;
            body_reg     <= 16'd0;
            kind_reg     <= ldh_pkg::KIND_DATA;
        end
        else if (accept)
        begin
            open_reg     <= open_next;
            send_cnt_reg <= send_cnt_next;
            rcv_cnt_reg  <= rcv_cnt_next;
            phase_reg    <= phase_next;
            body_reg     <= body_next;
            kind_reg     <= kind_next;
        end
    end

    // header byte store
    always_ff @(posedge clk)
    begin
        if (accept)
            hdr_reg <= hdr_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/ldh_out_buf.sv @@
// Result register with a skid stage between the parser and the output channel.
// Depends on ldh_pkg for the result type.
`default_nettype none

module ldh_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ldh_pkg::result_t  push_data,
    output logic                   push_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ldh_pkg::result_t       out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ldh_pkg::result_t  main_reg, main_next;
    ldh_pkg::result_t  skid_reg, skid_next;
    logic              main_free;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;
    assign main_free  = !main_valid_reg || out_ready;

    // move requests between input, skid and output registers
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
                main_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/link_deframer_with_heartbeat_unit.sv @@
// Top level of the link deframer with heartbeat supervision.
// Holds the configuration registers; instantiates ldh_core and ldh_out_buf (ldh_pkg).
//
//   channel   signals                                          direction
//   --------  -----------------------------------------------  ---------
//   input     in_valid, in_ready, command, rx_byte             in
//   output    out_valid, out_ready, event_res, data_byte,      out
//             message_length, error_code, send_heartbeat,
//             link_closing
//   config    cfg_we, cfg_index, cfg_data                      in
//
// One request per cycle while in_ready is high; the result is computed in the accepting
// cycle and registered at the accepting edge, in the output or else the skid register.
// The skid stage keeps in_ready high for one more request while out_ready is low;
// two results waiting stop the input until one is taken.
// Reset clears the link to closed, counters and parser to idle, limits to defaults.
`default_nettype none

module link_deframer_with_heartbeat_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_res,
    output logic [7:0]       data_byte,
    output logic [15:0]      message_length,
    output logic [2:0]       error_code,
    output logic             send_heartbeat,
    output logic             link_closing,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    ldh_pkg::cfg_t     cfg_reg;
    ldh_pkg::result_t  step_res;
    ldh_pkg::result_t  out_res;
    logic              accept;

    assign accept = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.send_idle_limit    <= ldh_pkg::SEND_IDLE_LIMIT_RST;
            cfg_reg.receive_idle_limit <= ldh_pkg::RECEIVE_IDLE_LIMIT_RST;
            cfg_reg.max_packet         <= ldh_pkg::MAX_PACKET_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ldh_pkg::CFG_SEND_IDLE_LIMIT)
                cfg_reg.send_idle_limit <= cfg_data[7:0];
            else if (cfg_index == ldh_pkg::CFG_RECEIVE_IDLE_LIMIT)
                cfg_reg.receive_idle_limit <= cfg_data[7:0];
            else if (cfg_index == ldh_pkg::CFG_MAX_PACKET)
                cfg_reg.max_packet <= cfg_data;
        end
    end

    ldh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .rx_byte (rx_byte),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

    ldh_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (step_res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_res)
    );

    // result fields to ports
    assign event_res      = out_res.ev;
    assign data_byte      = out_res.data_byte;
    assign message_length = out_res.message_length;
    assign error_code     = out_res.error_code;
    assign send_heartbeat = out_res.send_heartbeat;
    assign link_closing   = out_res.link_closing;

endmodule

`default_nettype wire

@@ dv/deframer_checker.sv @@
// Result checker for the link deframer with heartbeat supervision.
// Watches the request, result and configuration ports, predicts each result and compares it.
// Depends on ldh_pkg for command, event, error, phase and kind codes.
`timescale 1ns / 100ps

module deframer_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  event_res,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] message_length,
    input  wire logic [2:0]  error_code,
    input  wire logic        send_heartbeat,
    input  wire logic        link_closing,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               results_checked,
    output int               frames_done,
    output int               errors_seen,
    output int               heartbeats_asked,
    output logic             link_up
);

    // predicted configuration
    logic [7:0]  snd_limit;
    logic [7:0]  rcv_limit;
    logic [15:0] max_packet;

    // predicted link and parser state
    logic [7:0]         snd_idle;
    logic [7:0]         rcv_idle;
    ldh_pkg::phase_t    phase;
    logic [7:0]         hdr [0:5];
    logic [7:0]         trl_first;
    logic [15:0]        body_left;
    ldh_pkg::kind_t     kind;

    // results still owed by the block, oldest first
    ldh_pkg::result_t   owed_events [$];

    // closes the link and parks the parser
    task automatic drop_link();
        link_up   = 1'b0;
        snd_idle  = '0;
        rcv_idle  = '0;
        phase     = ldh_pkg::PH_HDR0;
        body_left = '0;
    endtask

    task automatic flag_error(input ldh_pkg::err_t code, inout ldh_pkg::result_t r);
        r.ev           = ldh_pkg::EV_ERROR;
        r.error_code   = code;
        r.link_closing = 1'b1;
        drop_link();
    endtask

    // one request in, one result out
    task automatic predict_deframe(input ldh_pkg::command_t cmd, input logic [7:0] b,
                                   output ldh_pkg::result_t r);
        logic [15:0] len;
        r = '0;
        case (cmd)
            ldh_pkg::CMD_RX_BYTE:
            begin
                if (link_up)
                begin
                    case (phase)
                        ldh_pkg::PH_HDR0, ldh_pkg::PH_HDR1, ldh_pkg::PH_HDR2,
                        ldh_pkg::PH_HDR3, ldh_pkg::PH_HDR4:
                        begin
                            hdr[phase] = b;
                            phase = ldh_pkg::phase_t'(phase + 4'd1);
                        end
                        ldh_pkg::PH_HDR5:
                        begin
                            hdr[5] = b;
                            len = {hdr[4], hdr[5]};
                            if (hdr[0] != ldh_pkg::HDR_MARK || hdr[1] != ldh_pkg::HDR_MARK)
                                flag_error(ldh_pkg::ERR_BAD_HEADER, r);
                            else
                            begin
                                rcv_idle = '0;
                                if (hdr[2] == ldh_pkg::ASCII_ZERO &&
                                    hdr[3] == ldh_pkg::ASCII_ZERO)
                                begin
                                    // length check done in 17 bits so it cannot wrap
                                    if ({1'b0, len} + 17'd2 > {1'b0, max_packet})
                                        flag_error(ldh_pkg::ERR_TOO_LONG, r);
                                    else
                                    begin
                                        kind      = ldh_pkg::KIND_DATA;
                                        body_left = len;
                                        phase     = (len == '0) ? ldh_pkg::PH_TRL0
                                                                : ldh_pkg::PH_BODY;
                                    end
                                end
                                else if (hdr[2] == ldh_pkg::ASCII_ONE &&
                                         (hdr[3] == ldh_pkg::ASCII_ZERO ||
                                          hdr[3] == ldh_pkg::ASCII_ONE))
                                begin
                                    kind  = (hdr[3] == ldh_pkg::ASCII_ZERO)
                                            ? ldh_pkg::KIND_ACCEPT
                                            : ldh_pkg::KIND_HEARTBEAT;
                                    phase = ldh_pkg::PH_TRL0;
                                end
                                else
                                    flag_error(ldh_pkg::ERR_UNKNOWN_CODE, r);
                            end
                        end
                        ldh_pkg::PH_BODY:
                        begin
                            r.ev        = ldh_pkg::EV_BODY_BYTE;
                            r.data_byte = b;
                            body_left   = body_left - 16'd1;
                            if (body_left == '0)
                                phase = ldh_pkg::PH_TRL0;
                        end
                        ldh_pkg::PH_TRL0:
                        begin
                            trl_first = b;
                            phase     = ldh_pkg::PH_TRL1;
                        end
                        ldh_pkg::PH_TRL1:
                        begin
                            if (trl_first != ldh_pkg::TRL_MARK || b != ldh_pkg::TRL_MARK)
                                flag_error(ldh_pkg::ERR_BAD_TRAILER, r);
                            else
                            begin
                                phase = ldh_pkg::PH_HDR0;
                                case (kind)
                                    ldh_pkg::KIND_DATA:
                                    begin
                                        r.ev             = ldh_pkg::EV_DATA_DONE;
                                        r.message_length = {hdr[4], hdr[5]};
                                    end
                                    ldh_pkg::KIND_ACCEPT:
                                        r.ev = ldh_pkg::EV_ACCEPT;
                                    default:
                                        r.ev = ldh_pkg::EV_HEARTBEAT;
                                endcase
                            end
                        end
                        default:
                            phase = ldh_pkg::PH_HDR0;
                    endcase
                end
            end
            ldh_pkg::CMD_TICK:
            begin
                if (link_up)
                begin
                    // both counters saturate, heartbeat first, then receive timeout
                    if (snd_idle != ldh_pkg::COUNT_MAX)
                        snd_idle = snd_idle + 8'd1;
                    if (rcv_idle != ldh_pkg::COUNT_MAX)
                        rcv_idle = rcv_idle + 8'd1;
                    if (snd_idle >= snd_limit)
                    begin
                        r.send_heartbeat = 1'b1;
                        snd_idle = '0;
                    end
                    if (rcv_idle >= rcv_limit)
                    begin
                        r.link_closing = 1'b1;
                        drop_link();
                    end
                end
            end
            ldh_pkg::CMD_OPEN:
            begin
                drop_link();
                link_up = 1'b1;
            end
            default:
                snd_idle = '0;
        endcase
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // track configuration, predict on each request, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        ldh_pkg::result_t fresh;
        ldh_pkg::result_t want;
        if (!rst_n)
        begin
            snd_limit        = ldh_pkg::SEND_IDLE_LIMIT_RST;
            rcv_limit        = ldh_pkg::RECEIVE_IDLE_LIMIT_RST;
            max_packet       = ldh_pkg::MAX_PACKET_RST;
            drop_link();
            kind             = ldh_pkg::KIND_DATA;
            trl_first        = '0;
            owed_events.delete();
            fail_count       = 0;
            pending          = 0;
            results_checked  = 0;
            frames_done      = 0;
            errors_seen      = 0;
            heartbeats_asked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ldh_pkg::CFG_SEND_IDLE_LIMIT:    snd_limit  = cfg_data[7:0];
                    ldh_pkg::CFG_RECEIVE_IDLE_LIMIT: rcv_limit  = cfg_data[7:0];
                    ldh_pkg::CFG_MAX_PACKET:         max_packet = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_deframe(ldh_pkg::command_t'(command), rx_byte, fresh);
                owed_events.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (owed_events.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result with nothing expected, event %0d error %0d",
                             $time, event_res, error_code);
                end
                else
                begin
                    want = owed_events.pop_front();
                    results_checked++;
                    if (want.ev inside {ldh_pkg::EV_DATA_DONE, ldh_pkg::EV_ACCEPT,
                                        ldh_pkg::EV_HEARTBEAT})
                        frames_done++;
                    if (want.ev == ldh_pkg::EV_ERROR)
                        errors_seen++;
                    if (want.send_heartbeat)
                        heartbeats_asked++;
                    compare_field("event_res", 16'(want.ev), 16'(event_res));
                    compare_field("data_byte", 16'(want.data_byte), 16'(data_byte));
                    compare_field("message_length", want.message_length, message_length);
                    compare_field("error_code", 16'(want.error_code), 16'(error_code));
                    compare_field("send_heartbeat", 16'(want.send_heartbeat),
                                  16'(send_heartbeat));
                    compare_field("link_closing", 16'(want.link_closing),
                                  16'(link_closing));
                end
            end
            pending = owed_events.size();
        end
    end

endmodule

@@ dv/link_deframer_with_heartbeat_unit_test.sv @@
// Testbench top for link_deframer_with_heartbeat_unit: clock, reset, requests and verdict.
// Drives framed byte streams, ticks and link events; deframer_checker does the comparing.
// Depends on ldh_pkg, deframer_checker and the block itself.
`timescale 1ns / 100ps

module link_deframer_with_heartbeat_unit_test;

    localparam int ITEM_TARGET    = 1150;
    localparam int PHASE_ITEMS    = 160;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    // ways a generated frame can be broken
    typedef enum int {
        FLAW_NONE,
        FLAW_MARK,
        FLAW_CODE,
        FLAW_LENGTH,
        FLAW_TRAILER
    } flaw_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic [2:0]  error_code;
    logic        send_heartbeat;
    logic        link_closing;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          results_checked;
    int          frames_done;
    int          errors_seen;
    int          heartbeats_asked;
    logic        link_up;

    int          items_sent;
    int          phases_run;
    int          stall_cycles = 0;
    bit          quiet;
    bit          hold_results;
    logic [15:0] cur_max_packet;

    link_deframer_with_heartbeat_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .data_byte      (data_byte),
        .message_length (message_length),
        .error_code     (error_code),
        .send_heartbeat (send_heartbeat),
        .link_closing   (link_closing),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    deframer_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_res        (event_res),
        .data_byte        (data_byte),
        .message_length   (message_length),
        .error_code       (error_code),
        .send_heartbeat   (send_heartbeat),
        .link_closing     (link_closing),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_checked  (results_checked),
        .frames_done      (frames_done),
        .errors_seen      (errors_seen),
        .heartbeats_asked (heartbeats_asked),
        .link_up          (link_up)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] off_mark(input logic [7:0] mark);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == mark)
            b = ~b;
        return b;
    endfunction

    // one request, held until the block takes it
    task automatic send_request(input ldh_pkg::command_t cmd, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        rx_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // sender idles until every result has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limits(input logic [7:0] snd, input logic [7:0] rcv,
                                input logic [15:0] maxp);
        cfg_we    = 1'b1;
        cfg_index = ldh_pkg::CFG_SEND_IDLE_LIMIT;
        cfg_data  = {8'($urandom), snd};
        @(negedge clk);
        cfg_index = ldh_pkg::CFG_RECEIVE_IDLE_LIMIT;
        cfg_data  = {8'($urandom), rcv};
        @(negedge clk);
        cfg_index = ldh_pkg::CFG_MAX_PACKET;
        cfg_data  = maxp;
        @(negedge clk);
        cfg_we    = 1'b0;
        cur_max_packet = maxp;
    endtask

    // one frame, well formed most of the time, with the odd tick or sent event mixed in
    task automatic send_frame();
        ldh_pkg::kind_t kind;
        flaw_t          flaw;
        logic [7:0]     frame_bytes [$];
        logic [7:0]     c0;
        logic [7:0]     c1;
        logic [15:0]    len;
        int             allowed;
        int             roll;
        int             which;
        roll = $urandom_range(99);
        kind = (roll < 60) ? ldh_pkg::KIND_DATA
             : (roll < 80) ? ldh_pkg::KIND_ACCEPT : ldh_pkg::KIND_HEARTBEAT;
        flaw = ($urandom_range(99) < 85) ? FLAW_NONE : flaw_t'($urandom_range(1, 4));
        if (flaw == FLAW_LENGTH)
            kind = ldh_pkg::KIND_DATA;
        allowed = int'(cur_max_packet) - 2;

        // control code, or a near miss of one
        c0 = (kind == ldh_pkg::KIND_DATA) ? ldh_pkg::ASCII_ZERO : ldh_pkg::ASCII_ONE;
        c1 = (kind == ldh_pkg::KIND_HEARTBEAT) ? ldh_pkg::ASCII_ONE : ldh_pkg::ASCII_ZERO;
        if (flaw == FLAW_CODE || (flaw == FLAW_MARK && $urandom_range(1)))
        begin
            do
            begin
                c0 = $urandom_range(1) ? 8'($urandom)
                                       : ldh_pkg::ASCII_ZERO + 8'($urandom_range(2));
                c1 = $urandom_range(1) ? 8'($urandom)
                                       : ldh_pkg::ASCII_ZERO + 8'($urandom_range(2));
            end
            while ((c0 == ldh_pkg::ASCII_ZERO && c1 == ldh_pkg::ASCII_ZERO) ||
                   (c0 == ldh_pkg::ASCII_ONE &&
                    (c1 == ldh_pkg::ASCII_ZERO || c1 == ldh_pkg::ASCII_ONE)));
        end

        // length: small bodies mostly, just over the limit or far over when too long
        if (flaw == FLAW_LENGTH)
            len = $urandom_range(1) ? 16'(allowed + 1)
                                    : 16'($urandom_range(allowed + 1, 65535));
        else if (kind != ldh_pkg::KIND_DATA)
            len = 16'($urandom);
        else if ($urandom_range(9) == 0)
            len = 16'($urandom_range((allowed < 64) ? allowed : 64));
        else
            len = 16'($urandom_range((allowed < 6) ? allowed : 6));

        // header
        which = $urandom_range(2);
        frame_bytes.push_back((flaw == FLAW_MARK && which != 1)
                              ? off_mark(ldh_pkg::HDR_MARK) : ldh_pkg::HDR_MARK);
        frame_bytes.push_back((flaw == FLAW_MARK && which != 0)
                              ? off_mark(ldh_pkg::HDR_MARK) : ldh_pkg::HDR_MARK);
        frame_bytes.push_back(c0);
        frame_bytes.push_back(c1);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);

        // body and trailer only when the header can pass
        if (flaw == FLAW_NONE || flaw == FLAW_TRAILER)
        begin
            if (kind == ldh_pkg::KIND_DATA)
                repeat (int'(len)) frame_bytes.push_back(8'($urandom));
            which = $urandom_range(2);
            frame_bytes.push_back((flaw == FLAW_TRAILER && which != 1)
                                  ? off_mark(ldh_pkg::TRL_MARK) : ldh_pkg::TRL_MARK);
            frame_bytes.push_back((flaw == FLAW_TRAILER && which != 0)
                                  ? off_mark(ldh_pkg::TRL_MARK) : ldh_pkg::TRL_MARK);
        end

        foreach (frame_bytes[i])
        begin
            if ($urandom_range(99) < 3)
                send_request($urandom_range(1) ? ldh_pkg::CMD_TICK : ldh_pkg::CMD_SENT,
                             8'($urandom));
            send_request(ldh_pkg::CMD_RX_BYTE, frame_bytes[i]);
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        bit hold_taken;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_results && !hold_taken)
            begin
                stall      = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            else
                stall = quiet ? 0 : pick_gap();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // watchdog on progress of either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no request or result moved for %0d cycles",
                         $time, stall_cycles);
                $display("[link_deframer_with_heartbeat_unit] ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int start_items;
        int roll;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = ldh_pkg::CMD_RX_BYTE;
        rx_byte        = '0;
        cfg_we         = 1'b0;
        cfg_index      = ldh_pkg::CFG_SEND_IDLE_LIMIT;
        cfg_data       = '0;
        items_sent     = 0;
        phases_run     = 0;
        quiet          = 1'b0;
        hold_results   = 1'b0;
        cur_max_packet = ldh_pkg::MAX_PACKET_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset limits: closed link ignores, then a two-byte data frame
        send_request(ldh_pkg::CMD_TICK, 8'hFF);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'hFF);
        send_request(ldh_pkg::CMD_OPEN, 8'h00);
        send_request(ldh_pkg::CMD_SENT, 8'h00);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::HDR_MARK);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::HDR_MARK);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::ASCII_ZERO);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::ASCII_ZERO);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'h00);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'h02);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'h00);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'hFF);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::TRL_MARK);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::TRL_MARK);

        // directed, tight limits: reopen while open, heartbeat and close on one tick,
        // then a header with a bad first mark
        wait_drained();
        write_limits(8'd1, 8'd2, 16'd4);
        send_request(ldh_pkg::CMD_OPEN, 8'hFF);
        send_request(ldh_pkg::CMD_TICK, 8'h00);
        send_request(ldh_pkg::CMD_TICK, 8'h00);
        send_request(ldh_pkg::CMD_OPEN, 8'h00);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'h00);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::HDR_MARK);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::ASCII_ONE);
        send_request(ldh_pkg::CMD_RX_BYTE, ldh_pkg::ASCII_ONE);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'h00);
        send_request(ldh_pkg::CMD_RX_BYTE, 8'h00);

        // random phases, each under its own limits
        while (items_sent < ITEM_TARGET)
        begin
            wait_drained();
            case (phases_run)
                0:       write_limits(8'd1, 8'd1, 16'd2);
                1:       write_limits(8'd3, 8'd5, 16'd12);
                2:       write_limits(ldh_pkg::SEND_IDLE_LIMIT_RST,
                                      ldh_pkg::RECEIVE_IDLE_LIMIT_RST,
                                      ldh_pkg::MAX_PACKET_RST);
                3:       write_limits(8'd255, 8'd255, 16'd65535);
                4:       write_limits(8'd2, 8'd8, 16'd40);
                default: write_limits(8'($urandom_range(1, 10)), 8'($urandom_range(1, 20)),
                                      16'($urandom_range(2, 100)));
            endcase
            quiet = (phases_run % 3 == 1);
            // long result hold-off while requests keep coming back to back
            if (phases_run == 2)
            begin
                quiet = 1'b1;
                hold_results = 1'b1;
            end
            // run both counters to the top limit on one open link
            if (phases_run == 3)
            begin
                send_request(ldh_pkg::CMD_OPEN, 8'($urandom));
                repeat (256) send_request(ldh_pkg::CMD_TICK, 8'($urandom));
            end
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS && items_sent < ITEM_TARGET)
            begin
                roll = $urandom_range(99);
                if (!link_up || roll < 3)
                    send_request(ldh_pkg::CMD_OPEN, 8'($urandom));
                else if (roll < 10)
                    repeat ($urandom_range(1, 4))
                        send_request(ldh_pkg::CMD_TICK, 8'($urandom));
                else if (roll < 13)
                    send_request(ldh_pkg::CMD_SENT, 8'($urandom));
                else if (roll < 16)
                    send_request(ldh_pkg::CMD_RX_BYTE, 8'($urandom));
                else
                    send_frame();
            end
            phases_run++;
        end

        // drain, let the pipeline settle, then report
        wait_drained();
        repeat (8) @(negedge clk);
        $display("run covered %0d requests over %0d limit settings, %0d results compared",
                 items_sent, phases_run + 2, results_checked);
        $display("%0d frames completed, %0d framing errors, %0d heartbeat requests",
                 frames_done, errors_seen, heartbeats_asked);
        if (fail_count == 0)
            $display("[link_deframer_with_heartbeat_unit] OK");
        else
            $display("[link_deframer_with_heartbeat_unit] ERROR");
        $finish;
    end

endmodule

@@ link_deframer_with_heartbeat_unit.f @@
hw/rtl/ldh_pkg.sv
hw/rtl/ldh_core.sv
hw/rtl/ldh_out_buf.sv
hw/rtl/link_deframer_with_heartbeat_unit.sv
dv/deframer_checker.sv
dv/link_deframer_with_heartbeat_unit_test.sv
